FILE: rtl/sbcc_pkg.sv
package sbcc_pkg;

  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 3;
  localparam int BOX_W         = 32;
  localparam int CHAIN_ID_W    = 12;
  localparam int POINT_IDX_W   = 16;
  localparam int POINT_LIMIT_W = 17;
  localparam int CHAIN_LIMIT_W = 13;
  localparam int CHAIN_TOTAL_W = 13;
  localparam int NUM_AXES      = 3;
  localparam int BUNDLE_DEPTH  = 3;
  localparam int BUNDLE_CNT_W  = 2;

  localparam logic [POINT_LIMIT_W-1:0] POINT_LIMIT_RESET = 17'd65536;
  localparam logic [CHAIN_LIMIT_W-1:0] CHAIN_LIMIT_RESET = 13'd4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BOX_LOW_X   = 3'd0,
    CFG_BOX_LOW_Y   = 3'd1,
    CFG_BOX_LOW_Z   = 3'd2,
    CFG_BOX_MAX_X   = 3'd3,
    CFG_BOX_MAX_Y   = 3'd4,
    CFG_BOX_MAX_Z   = 3'd5,
    CFG_POINT_LIMIT = 3'd6,
    CFG_CHAIN_LIMIT = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic                   has_segment;
    logic                   end_of_query;
    logic [CHAIN_ID_W-1:0]  chain_id;
    logic [POINT_IDX_W-1:0] point_index;
    logic                   touch;
  } seg_ctrl_t;

  typedef struct packed {
    kind_t                    kind;
    logic                     starts_chain;
    logic [CHAIN_TOTAL_W-1:0] chain_total;
    logic                     final_result;
  } res_meta_t;

endpackage

FILE: rtl/sbcc_if.sv
interface sbcc_seg_if #(parameter int COORD_BITS = 32);
  logic                                  valid;
  logic                                  ready;
  logic                                  has_segment;
  logic signed [COORD_BITS-1:0]          from_x;
  logic signed [COORD_BITS-1:0]          from_y;
  logic signed [COORD_BITS-1:0]          from_z;
  logic signed [COORD_BITS-1:0]          to_x;
  logic signed [COORD_BITS-1:0]          to_y;
  logic signed [COORD_BITS-1:0]          to_z;
  logic [sbcc_pkg::CHAIN_ID_W-1:0]       chain_id;
  logic [sbcc_pkg::POINT_IDX_W-1:0]      point_index;
  logic                                  end_of_query;

  modport source (
    output valid, has_segment, from_x, from_y, from_z, to_x, to_y, to_z,
           chain_id, point_index, end_of_query,
    input  ready
  );
  modport sink (
    input  valid, has_segment, from_x, from_y, from_z, to_x, to_y, to_z,
           chain_id, point_index, end_of_query,
    output ready
  );
endinterface

interface sbcc_res_if #(parameter int COORD_BITS = 32);
  logic                                  valid;
  logic                                  ready;
  sbcc_pkg::kind_t                       kind;
  logic signed [COORD_BITS-1:0]          point_x;
  logic signed [COORD_BITS-1:0]          point_y;
  logic signed [COORD_BITS-1:0]          point_z;
  logic                                  starts_chain;
  logic [sbcc_pkg::CHAIN_TOTAL_W-1:0]    chain_total;
  logic                                  final_result;

  modport source (
    output valid, kind, point_x, point_y, point_z, starts_chain, chain_total,
           final_result,
    input  ready
  );
  modport sink (
    input  valid, kind, point_x, point_y, point_z, starts_chain, chain_total,
           final_result,
    output ready
  );
endinterface

FILE: rtl/sbcc_cfg.sv
module sbcc_cfg #(
  parameter int MAX_POINTS = 65536,
  parameter int MAX_CHAINS = 4096,
  parameter int COORD_BITS = 32,
  parameter int PLW        = 18,
  parameter int CLW        = 14
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             cfg_we,
  input  logic [sbcc_pkg::CFG_INDEX_W-1:0]                 cfg_index,
  input  logic [sbcc_pkg::CFG_DATA_W-1:0]                  cfg_data,
  output logic [sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0]    box_low,
  output logic [sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0]    box_max,
  output logic [PLW-1:0]                                   plim,
  output logic [CLW-1:0]                                   clim
);
  import sbcc_pkg::*;

  logic [NUM_AXES-1:0][BOX_W-1:0] box_lo_r;
  logic [NUM_AXES-1:0][BOX_W-1:0] box_hi_r;
  logic [POINT_LIMIT_W-1:0]       point_limit;
  logic [CHAIN_LIMIT_W-1:0]       chain_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo_r    <= '0;
      box_hi_r    <= '0;
      point_limit <= POINT_LIMIT_RESET;
      chain_limit <= CHAIN_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_LOW_X:   box_lo_r[0] <= cfg_data[BOX_W-1:0];
        CFG_BOX_LOW_Y:   box_lo_r[1] <= cfg_data[BOX_W-1:0];
        CFG_BOX_LOW_Z:   box_lo_r[2] <= cfg_data[BOX_W-1:0];
        CFG_BOX_MAX_X:   box_hi_r[0] <= cfg_data[BOX_W-1:0];
        CFG_BOX_MAX_Y:   box_hi_r[1] <= cfg_data[BOX_W-1:0];
        CFG_BOX_MAX_Z:   box_hi_r[2] <= cfg_data[BOX_W-1:0];
        CFG_POINT_LIMIT: point_limit <= cfg_data[POINT_LIMIT_W-1:0];
        CFG_CHAIN_LIMIT: chain_limit <= cfg_data[CHAIN_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    if (COORD_BITS <= BOX_W) begin : g_trunc
      assign box_low[a] = box_lo_r[a][COORD_BITS-1:0];
      assign box_max[a] = box_hi_r[a][COORD_BITS-1:0];
    end else begin : g_ext
      assign box_low[a] = {{(COORD_BITS-BOX_W){1'b0}}, box_lo_r[a]};
      assign box_max[a] = {{(COORD_BITS-BOX_W){1'b0}}, box_hi_r[a]};
    end
  end

  assign plim = (PLW'(point_limit) > PLW'(MAX_POINTS)) ? PLW'(MAX_POINTS) : PLW'(point_limit);
  assign clim = (CLW'(chain_limit) > CLW'(MAX_CHAINS)) ? CLW'(MAX_CHAINS) : CLW'(chain_limit);

endmodule

FILE: rtl/sbcc_cull.sv
module sbcc_cull #(
  parameter int COORD_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  sbcc_seg_if.sink                                      seg,
  input  logic [sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] box_low,
  input  logic [sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] box_max,
  input  logic                                          take,
  output logic                                          s1_valid,
  output sbcc_pkg::seg_ctrl_t                           s1_ctrl,
  output logic [sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] s1_from,
  output logic [sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] s1_to
);
  import sbcc_pkg::*;

  logic [NUM_AXES-1:0][COORD_BITS-1:0] from_v;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] to_v;
  logic [NUM_AXES-1:0]                 axis_hit;

  assign from_v = {seg.from_z, seg.from_y, seg.from_x};
  assign to_v   = {seg.to_z, seg.to_y, seg.to_x};

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_hit[a] = (($signed(from_v[a]) >= $signed(box_low[a])) ||
                     ($signed(to_v[a])   >= $signed(box_low[a]))) &&
                    (($signed(from_v[a]) <= $signed(box_max[a])) ||
                     ($signed(to_v[a])   <= $signed(box_max[a])));
    end
  end

  assign seg.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (seg.ready) begin
      s1_valid <= seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg.valid && seg.ready) begin
      s1_ctrl.has_segment  <= seg.has_segment;
      s1_ctrl.end_of_query <= seg.end_of_query;
      s1_ctrl.chain_id     <= seg.chain_id;
      s1_ctrl.point_index  <= seg.point_index;
      s1_ctrl.touch        <= &axis_hit;
      s1_from              <= from_v;
      s1_to                <= to_v;
    end
  end

endmodule

FILE: rtl/sbcc_coalesce.sv
module sbcc_coalesce #(
  parameter int COORD_BITS = 32,
  parameter int PW         = 17,
  parameter int KW         = 13,
  parameter int PLW        = 18,
  parameter int CLW        = 14
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s1_valid,
  input  sbcc_pkg::seg_ctrl_t                           s1_ctrl,
  input  logic [sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] s1_from,
  input  logic [sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] s1_to,
  input  logic [PLW-1:0]                                plim,
  input  logic [CLW-1:0]                                clim,
  input  logic                                          bnd_free,
  output logic                                          take,
  output logic                                          bnd_load,
  output logic [sbcc_pkg::BUNDLE_CNT_W-1:0]             bnd_count,
  output sbcc_pkg::res_meta_t [sbcc_pkg::BUNDLE_DEPTH-1:0] bnd_meta,
  output logic [sbcc_pkg::BUNDLE_DEPTH-1:0][sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] bnd_pt
);
  import sbcc_pkg::*;

  logic                     run_open, run_open_next;
  logic [CHAIN_ID_W-1:0]    prev_chain, prev_chain_next;
  logic [POINT_IDX_W-1:0]   prev_point, prev_point_next;
  logic [PW-1:0]            points_sent, points_sent_next;
  logic [KW-1:0]            chains_sent, chains_sent_next;
  logic                     query_failed, query_failed_next;

  logic                     seg_work;
  logic                     cont;
  logic                     fail_ext;
  logic                     fail_new;
  logic [BUNDLE_CNT_W-1:0]  n_res;
  logic [CHAIN_TOTAL_W-1:0] total;

  assign seg_work = s1_ctrl.has_segment && !query_failed && s1_ctrl.touch;
  assign cont     = run_open && (s1_ctrl.chain_id == prev_chain) &&
                    ({1'b0, s1_ctrl.point_index} ==
                     ({1'b0, prev_point} + (POINT_IDX_W+1)'(1)));
  assign fail_ext = (PLW'(points_sent) + PLW'(1)) > plim;
  assign fail_new = ((CLW'(chains_sent) + CLW'(1)) >= clim) ||
                    ((PLW'(points_sent) + PLW'(2)) > plim);

  always_comb begin
    run_open_next     = run_open;
    prev_chain_next   = prev_chain;
    prev_point_next   = prev_point;
    points_sent_next  = points_sent;
    chains_sent_next  = chains_sent;
    query_failed_next = query_failed;
    n_res             = '0;
    bnd_meta          = '0;
    bnd_pt            = '0;

    if (seg_work) begin
      if (cont ? fail_ext : fail_new) begin
        query_failed_next        = 1'b1;
        bnd_meta[0].kind         = KIND_FAIL;
        bnd_meta[0].final_result = 1'b1;
        n_res                    = BUNDLE_CNT_W'(1);
      end else begin
        run_open_next   = 1'b1;
        prev_chain_next = s1_ctrl.chain_id;
        prev_point_next = s1_ctrl.point_index;
        if (cont) begin
          points_sent_next = points_sent + PW'(1);
          bnd_meta[0].kind = KIND_POINT;
          bnd_pt[0]        = s1_to;
          n_res            = BUNDLE_CNT_W'(1);
        end else begin
          points_sent_next         = points_sent + PW'(2);
          chains_sent_next         = chains_sent + KW'(1);
          bnd_meta[0].kind         = KIND_POINT;
          bnd_meta[0].starts_chain = 1'b1;
          bnd_pt[0]                = s1_from;
          bnd_meta[1].kind         = KIND_POINT;
          bnd_pt[1]                = s1_to;
          n_res                    = BUNDLE_CNT_W'(2);
        end
      end
    end

    total = CHAIN_TOTAL_W'(chains_sent_next);

    if (s1_ctrl.end_of_query) begin
      if (!query_failed_next) begin
        bnd_meta[n_res].kind         = KIND_DONE;
        bnd_meta[n_res].final_result = 1'b1;
        n_res                        = n_res + BUNDLE_CNT_W'(1);
      end
      run_open_next     = 1'b0;
      prev_chain_next   = '0;
      prev_point_next   = '0;
      points_sent_next  = '0;
      chains_sent_next  = '0;
      query_failed_next = 1'b0;
    end

    for (int i = 0; i < BUNDLE_DEPTH; i++) begin
      bnd_meta[i].chain_total = total;
    end
  end

  assign take      = s1_valid && ((n_res == '0) || bnd_free);
  assign bnd_load  = take && (n_res != '0);
  assign bnd_count = n_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open     <= 1'b0;
      prev_chain   <= '0;
      prev_point   <= '0;
      points_sent  <= '0;
      chains_sent  <= '0;
      query_failed <= 1'b0;
    end else if (take) begin
      run_open     <= run_open_next;
      prev_chain   <= prev_chain_next;
      prev_point   <= prev_point_next;
      points_sent  <= points_sent_next;
      chains_sent  <= chains_sent_next;
      query_failed <= query_failed_next;
    end
  end

endmodule

FILE: rtl/sbcc_emit.sv
module sbcc_emit #(
  parameter int COORD_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  logic [sbcc_pkg::BUNDLE_CNT_W-1:0]             count,
  input  sbcc_pkg::res_meta_t [sbcc_pkg::BUNDLE_DEPTH-1:0] meta,
  input  logic [sbcc_pkg::BUNDLE_DEPTH-1:0][sbcc_pkg::NUM_AXES-1:0][COORD_BITS-1:0] pt,
  output logic                                          free,
  sbcc_res_if.source                                    res
);
  import sbcc_pkg::*;

  logic [BUNDLE_CNT_W-1:0]                             cnt;
  res_meta_t [BUNDLE_DEPTH-1:0]                        meta_q;
  logic [BUNDLE_DEPTH-1:0][NUM_AXES-1:0][COORD_BITS-1:0] pt_q;
  logic                                                xfer;

  assign xfer = res.valid && res.ready;
  assign free = (cnt == '0) || ((cnt == BUNDLE_CNT_W'(1)) && res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= count;
    end else if (xfer) begin
      cnt <= cnt - BUNDLE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_q <= meta;
      pt_q   <= pt;
    end else if (xfer) begin
      for (int i = 0; i < BUNDLE_DEPTH - 1; i++) begin
        meta_q[i] <= meta_q[i+1];
        pt_q[i]   <= pt_q[i+1];
      end
    end
  end

  assign res.valid        = (cnt != '0);
  assign res.kind         = meta_q[0].kind;
  assign res.point_x      = pt_q[0][0];
  assign res.point_y      = pt_q[0][1];
  assign res.point_z      = pt_q[0][2];
  assign res.starts_chain = meta_q[0].starts_chain;
  assign res.chain_total  = meta_q[0].chain_total;
  assign res.final_result = meta_q[0].final_result;

endmodule

FILE: rtl/segment_box_cull_coalesce.sv
// Segment box cull with subchain coalescing. Segments enter on seg, are tested against the
// query box written through the configuration port, and leave on res as points,
// a done marker or a capacity failure. An item is registered after the box test, passes
// the combinational coalescing logic and is loaded into the result buffer, from which res
// offers its first result; the item waits in the box test register while the buffer is busy.
// The block takes one item per cycle while each item yields at most one result and res keeps
// up; an item that opens a subchain yields two or three results, and since res moves one
// result per cycle while ready from the three-entry result buffer, the next item waits until
// the last of them transfers. Configuration writes take effect at the next clock.
module segment_box_cull_coalesce #(
  parameter int MAX_POINTS = 65536,
  parameter int MAX_CHAINS = 4096,
  parameter int COORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sbcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  sbcc_seg_if.sink                         seg,
  sbcc_res_if.source                       res
);
  import sbcc_pkg::*;

  localparam int PW  = $clog2(MAX_POINTS + 1);
  localparam int KW  = $clog2(MAX_CHAINS + 1);
  localparam int PLW = ((PW > POINT_LIMIT_W) ? PW : POINT_LIMIT_W) + 1;
  localparam int CLW = ((KW > CHAIN_LIMIT_W) ? KW : CHAIN_LIMIT_W) + 1;

  logic [NUM_AXES-1:0][COORD_BITS-1:0]                 box_low;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]                 box_max;
  logic [PLW-1:0]                                      plim;
  logic [CLW-1:0]                                      clim;
  logic                                                take;
  logic                                                s1_valid;
  seg_ctrl_t                                           s1_ctrl;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]                 s1_from;
  logic [NUM_AXES-1:0][COORD_BITS-1:0]                 s1_to;
  logic                                                bnd_free;
  logic                                                bnd_load;
  logic [BUNDLE_CNT_W-1:0]                             bnd_count;
  res_meta_t [BUNDLE_DEPTH-1:0]                        bnd_meta;
  logic [BUNDLE_DEPTH-1:0][NUM_AXES-1:0][COORD_BITS-1:0] bnd_pt;

  sbcc_cfg #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_CHAINS (MAX_CHAINS),
    .COORD_BITS (COORD_BITS),
    .PLW        (PLW),
    .CLW        (CLW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box_low   (box_low),
    .box_max   (box_max),
    .plim      (plim),
    .clim      (clim)
  );

  sbcc_cull #(
    .COORD_BITS (COORD_BITS)
  ) u_cull (
    .clk      (clk),
    .rst      (rst),
    .seg      (seg),
    .box_low  (box_low),
    .box_max  (box_max),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_ctrl  (s1_ctrl),
    .s1_from  (s1_from),
    .s1_to    (s1_to)
  );

  sbcc_coalesce #(
    .COORD_BITS (COORD_BITS),
    .PW         (PW),
    .KW         (KW),
    .PLW        (PLW),
    .CLW        (CLW)
  ) u_coalesce (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ctrl   (s1_ctrl),
    .s1_from   (s1_from),
    .s1_to     (s1_to),
    .plim      (plim),
    .clim      (clim),
    .bnd_free  (bnd_free),
    .take      (take),
    .bnd_load  (bnd_load),
    .bnd_count (bnd_count),
    .bnd_meta  (bnd_meta),
    .bnd_pt    (bnd_pt)
  );

  sbcc_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk   (clk),
    .rst   (rst),
    .load  (bnd_load),
    .count (bnd_count),
    .meta  (bnd_meta),
    .pt    (bnd_pt),
    .free  (bnd_free),
    .res   (res)
  );

endmodule
